// File: rtl/tfn_pkg.sv
`default_nettype none
package tfn_pkg;

	localparam int IDX_W   = 24;
	localparam int POS_W   = 32;
	localparam int EDGE_W  = POS_W + 1;
	localparam int NRM_W   = 16;
	localparam int CROSS_W = 2 * NRM_W - 1;
	// Quotient of square over sum of squares, scaled by 2^30, and its root.
	localparam int QUO_W   = 2 * (NRM_W - 1) + 1;
	localparam int ROOT_W  = NRM_W;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_ZERO_EDGE = 2'd1;
	localparam logic [1:0] ST_COLLINEAR = 2'd2;

	typedef struct packed {
		logic        [IDX_W-1:0] index_a;
		logic        [IDX_W-1:0] index_b;
		logic        [IDX_W-1:0] index_c;
		logic signed [POS_W-1:0] ax;
		logic signed [POS_W-1:0] ay;
		logic signed [POS_W-1:0] az;
		logic signed [POS_W-1:0] bx;
		logic signed [POS_W-1:0] by_coord;
		logic signed [POS_W-1:0] bz;
		logic signed [POS_W-1:0] cx;
		logic signed [POS_W-1:0] cy;
		logic signed [POS_W-1:0] cz;
	} tfn_req_t;

	typedef struct packed {
		logic        [IDX_W-1:0] out_index_a;
		logic        [IDX_W-1:0] out_index_b;
		logic        [IDX_W-1:0] out_index_c;
		logic signed [NRM_W-1:0] normal_x;
		logic signed [NRM_W-1:0] normal_y;
		logic signed [NRM_W-1:0] normal_z;
		logic        [1:0]       status;
	} tfn_rsp_t;

endpackage
`default_nettype wire

// File: rtl/tfn_norm.sv
`default_nettype none
module tfn_norm #(
	parameter int VW = 33,
	parameter int TW = 48
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_vld,
	input  logic [2:0][VW-1:0]                    in_v,
	input  logic [TW-1:0]                         in_tag,
	output logic                                  out_vld,
	output logic [2:0][tfn_pkg::NRM_W-1:0]        out_n,
	output logic                                  out_nz,
	output logic [TW-1:0]                         out_tag
);
	import tfn_pkg::*;

	localparam int MW  = VW;
	localparam int H   = (MW + 1) / 2;
	localparam int HW  = MW - H;
	localparam int SQW = 2 * MW;
	localparam int SW  = SQW + 2;
	localparam int QW  = QUO_W;
	localparam int GW  = ROOT_W;
	localparam int LAT = 4 + QW + GW + 1;
	localparam logic signed [NRM_W-1:0] N_ONE = NRM_W'(1) << (NRM_W - 2);

	logic              vld_p  [1:LAT];
	logic [TW-1:0]     tag_p  [1:LAT];
	logic [2:0]        neg_p  [1:LAT-1];
	logic              zero_p [1:LAT-1];

	logic [2:0][MW-1:0]       mag_s1;
	logic [2:0][2*HW-1:0]     hh_s2;
	logic [2:0][HW+H-1:0]     hl_s2;
	logic [2:0][2*H-1:0]      ll_s2;
	logic [2:0][SQW-1:0]      sq_s3;
	logic [2:0][SQW-1:0]      sq_s4;
	logic [SW-1:0]            ssum_s4;

	logic [2:0][SW-1:0]       dv_rem_s [QW-1];
	logic [SW-1:0]            dv_den_s [QW-1];
	logic [2:0][QW-1:0]       dv_quo_s [QW];

	logic [2:0][GW-1:0]       sr_g_s   [GW];
	logic [2:0][QW-1:0]       sr_rad_s [GW-1];

	logic [2:0][NRM_W-1:0]    nrm_q;
	logic                     nz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LAT; i++) vld_p[i] <= 1'b0;
		end else begin
			vld_p[1] <= in_vld;
			for (int i = 2; i <= LAT; i++) vld_p[i] <= vld_p[i-1];
		end
	end

	always_ff @(posedge clk) begin
		tag_p[1]  <= in_tag;
		neg_p[1]  <= {in_v[2][VW-1], in_v[1][VW-1], in_v[0][VW-1]};
		zero_p[1] <= (in_v == '0);
		for (int i = 2; i <= LAT; i++) tag_p[i] <= tag_p[i-1];
		for (int i = 2; i <= LAT - 1; i++) begin
			neg_p[i]  <= neg_p[i-1];
			zero_p[i] <= zero_p[i-1];
		end
	end

	// Squares are built from half-width partial products.
	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			mag_s1[c] <= in_v[c][VW-1] ? MW'(0) - in_v[c] : in_v[c];
			hh_s2[c]  <= (2*HW)'(mag_s1[c][MW-1:H]) * (2*HW)'(mag_s1[c][MW-1:H]);
			hl_s2[c]  <= (HW+H)'(mag_s1[c][MW-1:H]) * (HW+H)'(mag_s1[c][H-1:0]);
			ll_s2[c]  <= (2*H)'(mag_s1[c][H-1:0]) * (2*H)'(mag_s1[c][H-1:0]);
			sq_s3[c]  <= (SQW'(hh_s2[c]) << (2 * H)) + (SQW'(hl_s2[c]) << (H + 1))
				+ SQW'(ll_s2[c]);
		end
		sq_s4   <= sq_s3;
		ssum_s4 <= SW'(sq_s3[0]) + SW'(sq_s3[1]) + SW'(sq_s3[2]);
	end

	// Restoring division: quotient = floor(square * 2^30 / sum), one bit per stage.
	// The square never exceeds the sum, so the first step yields at most one.
	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [2:0][SW:0]   trial;
		logic [SW-1:0]      den;
		logic [2:0][QW-1:0] qin;
		logic [2:0]         ge;

		if (k == 0) begin : g_first
			always_comb begin
				den = ssum_s4;
				for (int c = 0; c < 3; c++) begin
					trial[c] = (SW+1)'(sq_s4[c]);
					qin[c]   = '0;
				end
			end
		end else begin : g_next
			always_comb begin
				den = dv_den_s[k-1];
				for (int c = 0; c < 3; c++) begin
					trial[c] = {dv_rem_s[k-1][c], 1'b0};
					qin[c]   = dv_quo_s[k-1][c];
				end
			end
		end

		always_comb begin
			for (int c = 0; c < 3; c++) ge[c] = (trial[c] >= (SW+1)'(den));
		end

		always_ff @(posedge clk) begin
			for (int c = 0; c < 3; c++) dv_quo_s[k][c] <= {qin[c][QW-2:0], ge[c]};
		end

		if (k < QW - 1) begin : g_keep
			always_ff @(posedge clk) begin
				dv_den_s[k] <= den;
				for (int c = 0; c < 3; c++) begin
					dv_rem_s[k][c] <= ge[c] ? SW'(trial[c] - (SW+1)'(den)) : SW'(trial[c]);
				end
			end
		end
	end

	// Integer square root of the quotient, one result bit per stage.
	for (genvar j = 0; j < GW; j++) begin : g_root
		logic [2:0][GW-1:0]   g_in;
		logic [2:0][QW-1:0]   rad;
		logic [2:0][GW-1:0]   t;
		logic [2:0][2*GW-1:0] tt;

		if (j == 0) begin : g_first
			always_comb begin
				g_in = '0;
				rad  = dv_quo_s[QW-1];
			end
		end else begin : g_next
			always_comb begin
				g_in = sr_g_s[j-1];
				rad  = sr_rad_s[j-1];
			end
		end

		always_comb begin
			for (int c = 0; c < 3; c++) begin
				t[c]  = g_in[c] | (GW'(1) << (GW - 1 - j));
				tt[c] = (2*GW)'(t[c]) * (2*GW)'(t[c]);
			end
		end

		always_ff @(posedge clk) begin
			for (int c = 0; c < 3; c++)
				sr_g_s[j][c] <= (tt[c] <= (2*GW)'(rad[c])) ? t[c] : g_in[c];
		end

		if (j < GW - 1) begin : g_keep
			always_ff @(posedge clk) begin
				sr_rad_s[j] <= rad;
			end
		end
	end

	// The largest odd root bound 2r-1 <= g gives r = (g+1)/2.
	logic [2:0][GW:0]   rnd;
	logic [2:0][GW-1:0] rmag;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			rnd[c]  = (GW+1)'(sr_g_s[GW-1][c]) + (GW+1)'(1);
			rmag[c] = rnd[c][GW:1];
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			if (zero_p[LAT-1])
				nrm_q[c] <= '0;
			else if (neg_p[LAT-1][c])
				nrm_q[c] <= NRM_W'(0) - NRM_W'(rmag[c]);
			else
				nrm_q[c] <= NRM_W'(rmag[c]);
		end
		nz_q <= !zero_p[LAT-1];
	end

	assign out_vld = vld_p[LAT];
	assign out_n   = nrm_q;
	assign out_nz  = nz_q;
	assign out_tag = tag_p[LAT];

	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_vld |-> ##LAT out_vld)
		else $error("normalizer lost a request");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld |-> ($signed(out_n[0]) <= N_ONE && $signed(out_n[0]) >= -N_ONE
			&& $signed(out_n[1]) <= N_ONE && $signed(out_n[1]) >= -N_ONE
			&& $signed(out_n[2]) <= N_ONE && $signed(out_n[2]) >= -N_ONE))
		else $error("normalized component out of range");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld && !out_nz |-> out_n == '0)
		else $error("zero vector gave a nonzero result");

endmodule
`default_nettype wire

// File: rtl/tfn_cross.sv
`default_nettype none
module tfn_cross #(
	parameter int TW = 73
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_vld,
	input  logic [2:0][tfn_pkg::NRM_W-1:0]        n0,
	input  logic [2:0][tfn_pkg::NRM_W-1:0]        n1,
	input  logic [TW-1:0]                         in_tag,
	output logic                                  out_vld,
	output logic [2:0][tfn_pkg::CROSS_W-1:0]      out_c,
	output logic [TW-1:0]                         out_tag
);
	import tfn_pkg::*;

	localparam int PW = 2 * NRM_W;
	// Unit inputs keep every component of the cross product within 2^29.
	localparam logic signed [CROSS_W-1:0] C_MAX = CROSS_W'(1) << (2 * NRM_W - 3);

	logic                  vld_s1, vld_s2;
	logic [TW-1:0]         tag_s1, tag_s2;
	logic [5:0][PW-1:0]    p_s1;
	logic [2:0][CROSS_W-1:0] c_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1  <= in_tag;
		tag_s2  <= tag_s1;
		p_s1[0] <= PW'($signed(n0[1])) * PW'($signed(n1[2]));
		p_s1[1] <= PW'($signed(n0[2])) * PW'($signed(n1[1]));
		p_s1[2] <= PW'($signed(n0[2])) * PW'($signed(n1[0]));
		p_s1[3] <= PW'($signed(n0[0])) * PW'($signed(n1[2]));
		p_s1[4] <= PW'($signed(n0[0])) * PW'($signed(n1[1]));
		p_s1[5] <= PW'($signed(n0[1])) * PW'($signed(n1[0]));
		c_s2[0] <= CROSS_W'(p_s1[0] - p_s1[1]);
		c_s2[1] <= CROSS_W'(p_s1[2] - p_s1[3]);
		c_s2[2] <= CROSS_W'(p_s1[4] - p_s1[5]);
	end

	assign out_vld = vld_s2;
	assign out_c   = c_s2;
	assign out_tag = tag_s2;

	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_vld |-> ##2 out_vld)
		else $error("cross product lost a request");

	a_src: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld |-> $past(in_vld, 2))
		else $error("cross product produced a request from nothing");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld |-> ($signed(out_c[0]) <= C_MAX && $signed(out_c[0]) >= -C_MAX
			&& $signed(out_c[1]) <= C_MAX && $signed(out_c[1]) >= -C_MAX
			&& $signed(out_c[2]) <= C_MAX && $signed(out_c[2]) >= -C_MAX))
		else $error("cross product component out of range");

endmodule
`default_nettype wire

// File: rtl/triangle_face_normal.sv
`default_nettype none
// Flat face normal of one triangle.
//
// A request is three vertex indices and three signed Q16.16 corners on req.
// It is taken at a rising edge where start is high and busy is low; busy is
// always low, so a new triangle can enter on every clock cycle.
// The block forms the edges a-b and b-c, normalizes each to Q1.14, takes
// their cross product and normalizes that. Each normalizer divides a square
// by the sum of squares one quotient bit per stage and then takes an integer
// square root one bit per stage, so the pipeline is made up of 1 edge stage,
// 52 normalizer stages, 2 cross product stages, 52 normalizer stages and 1
// output stage.
// Throughput is one triangle per cycle.
// Each result is shown on rsp for exactly one cycle with done high. The
// receiver cannot stall, so results are never held. status reports a
// zero-length edge or collinear edges; in both cases the normal is zero.
// Reset clears all valid bits in the pipeline; requests in flight are dropped.
module triangle_face_normal (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  tfn_pkg::tfn_req_t req,
	output logic              done,
	output tfn_pkg::tfn_rsp_t rsp
);
	import tfn_pkg::*;

	localparam int TW2 = 3 * IDX_W + 1;

	logic                    vld_s1;
	logic [2:0][EDGE_W-1:0]  e0_s1, e1_s1;
	logic [3*IDX_W-1:0]      idx_s1;

	logic                    n0_vld, n1_vld, n0_nz, n1_nz;
	logic [2:0][NRM_W-1:0]   n0_v, n1_v;
	logic [2*IDX_W-1:0]      n0_tag;
	logic [IDX_W-1:0]        n1_tag;

	logic                    cr_vld;
	logic [2:0][CROSS_W-1:0] cr_v;
	logic [TW2-1:0]          cr_tag;

	logic                    nf_vld, nf_nz;
	logic [2:0][NRM_W-1:0]   nf_v;
	logic [TW2-1:0]          nf_tag;

	logic                    done_q;
	tfn_rsp_t                rsp_q;
	logic                    edge_zero;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1   <= {req.index_a, req.index_b, req.index_c};
		e0_s1[0] <= EDGE_W'(req.ax) - EDGE_W'(req.bx);
		e0_s1[1] <= EDGE_W'(req.ay) - EDGE_W'(req.by_coord);
		e0_s1[2] <= EDGE_W'(req.az) - EDGE_W'(req.bz);
		e1_s1[0] <= EDGE_W'(req.bx) - EDGE_W'(req.cx);
		e1_s1[1] <= EDGE_W'(req.by_coord) - EDGE_W'(req.cy);
		e1_s1[2] <= EDGE_W'(req.bz) - EDGE_W'(req.cz);
	end

	// Both edge normalizers take vld_s1 and share VW, so their outputs stay aligned; the indices ride split across them.
	tfn_norm #(.VW(EDGE_W), .TW(2 * IDX_W)) u_norm_e0 (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s1),
		.in_v    (e0_s1),
		.in_tag  (idx_s1[3*IDX_W-1:IDX_W]),
		.out_vld (n0_vld),
		.out_n   (n0_v),
		.out_nz  (n0_nz),
		.out_tag (n0_tag)
	);

	tfn_norm #(.VW(EDGE_W), .TW(IDX_W)) u_norm_e1 (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s1),
		.in_v    (e1_s1),
		.in_tag  (idx_s1[IDX_W-1:0]),
		.out_vld (n1_vld),
		.out_n   (n1_v),
		.out_nz  (n1_nz),
		.out_tag (n1_tag)
	);

	tfn_cross #(.TW(TW2)) u_cross (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (n0_vld),
		.n0      (n0_v),
		.n1      (n1_v),
		.in_tag  ({n0_tag, n1_tag, !(n0_nz && n1_nz)}),
		.out_vld (cr_vld),
		.out_c   (cr_v),
		.out_tag (cr_tag)
	);

	tfn_norm #(.VW(CROSS_W), .TW(TW2)) u_norm_face (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (cr_vld),
		.in_v    (cr_v),
		.in_tag  (cr_tag),
		.out_vld (nf_vld),
		.out_n   (nf_v),
		.out_nz  (nf_nz),
		.out_tag (nf_tag)
	);

	assign edge_zero = nf_tag[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= nf_vld;
		end
	end

	always_ff @(posedge clk) begin
		rsp_q.out_index_a <= nf_tag[TW2-1 -: IDX_W];
		rsp_q.out_index_b <= nf_tag[TW2-1-IDX_W -: IDX_W];
		rsp_q.out_index_c <= nf_tag[IDX_W:1];
		if (edge_zero) begin
			rsp_q.normal_x <= '0;
			rsp_q.normal_y <= '0;
			rsp_q.normal_z <= '0;
			rsp_q.status   <= ST_ZERO_EDGE;
		end else begin
			rsp_q.normal_x <= nf_v[0];
			rsp_q.normal_y <= nf_v[1];
			rsp_q.normal_z <= nf_v[2];
			rsp_q.status   <= nf_nz ? ST_OK : ST_COLLINEAR;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	a_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		n0_vld == n1_vld)
		else $error("edge normalizers left lockstep");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != ST_OK |->
			rsp.normal_x == '0 && rsp.normal_y == '0 && rsp.normal_z == '0)
		else $error("failed request carries a nonzero normal");

	a_ok_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status == ST_OK |->
			!(rsp.normal_x == '0 && rsp.normal_y == '0 && rsp.normal_z == '0))
		else $error("good request produced a zero normal");

endmodule
`default_nettype wire
